[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PDW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PDW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pdw_pkg.sv]
// ----------------------------------------------------------------------------
// pdw_pkg
// Types and constants shared by the pulse descriptor blocks.
// ----------------------------------------------------------------------------
package pdw_pkg;

    // Consecutive qualifying samples needed to confirm a start / an end.
    localparam logic [2:0] START_RUN = 3'd3;
    localparam logic [2:0] END_RUN   = 3'd3;

    // Descriptor queue between detector and divider.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_START_THR = 2'd0;
    localparam logic [1:0] REG_END_THR   = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;

    localparam logic [15:0] START_THR_RST = 16'd655;
    localparam logic [15:0] END_THR_RST   = 16'd655;
    localparam logic [15:0] PERIOD_RST    = 16'd100;

    typedef struct packed {
        logic [15:0] start_thr;
        logic [15:0] end_thr;
        logic [15:0] period;
    } cfg_t;

    // Finished pulse, waiting for the mean to be computed.
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] toa;
        logic [31:0] width;
        logic [31:0] amp_sum;
        logic [15:0] amp_cnt;
    } summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

[hdl/pdw_front.sv]
// ----------------------------------------------------------------------------
// pdw_front
// Pulse start/end detector: one sample per cycle while the queue has room, pushes pulse summaries.
// ----------------------------------------------------------------------------
module pdw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pdw_pkg::cfg_t     cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // [15:0] sample_amplitude, [47:16] sample_time
    input  logic              q_full,
    output logic              push,
    output pdw_pkg::summary_t push_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MAYBE_START,
        PH_IN_PULSE,
        PH_MAYBE_END
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  run_reg, run_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] end_reg, end_next;
    logic [31:0] sum_reg, sum_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] tsum_reg, tsum_next;
    logic [15:0] tcnt_reg, tcnt_next;
    logic [31:0] seq_reg, seq_next;

    logic        in_fire;
    logic [15:0] amp;
    logic [31:0] stamp;
    logic [31:0] amp32;
    logic [2:0]  run_inc;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;
    assign amp      = s_tdata[15:0];
    assign stamp    = s_tdata[47:16];
    assign amp32    = {16'd0, amp};
    assign run_inc  = (run_reg == 3'd7) ? 3'd7 : run_reg + 3'd1;

    // Summary reflects the current pulse; only pushed on a confirmed end.
    assign push_data.seq     = seq_reg + 32'd1;
    assign push_data.toa     = start_reg;
    assign push_data.width   = end_reg - start_reg + {16'd0, cfg.period};
    assign push_data.amp_sum = sum_reg;
    assign push_data.amp_cnt = cnt_reg;

    always_comb
    begin
        phase_next = phase_reg;
        run_next   = run_reg;
        start_next = start_reg;
        end_next   = end_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        tsum_next  = tsum_reg;
        tcnt_next  = tcnt_reg;
        seq_next   = seq_reg;
        push       = 1'b0;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (amp >= cfg.start_thr)
                    begin
                        run_next   = 3'd1;
                        start_next = stamp;
                        end_next   = stamp;
                        sum_next   = amp32;
                        cnt_next   = 16'd1;
                        phase_next = (3'd1 >= pdw_pkg::START_RUN) ? PH_IN_PULSE
                                                                  : PH_MAYBE_START;
                    end
                end
                PH_MAYBE_START:
                begin
                    if (amp >= cfg.start_thr)
                    begin
                        run_next = run_inc;
                        if (run_inc >= pdw_pkg::START_RUN)
                            phase_next = PH_IN_PULSE;
                        // end time follows start samples too (short pulses)
                        end_next = stamp;
                        sum_next = sat_add32(sum_reg, amp32);
                        cnt_next = sat_add16(cnt_reg, 16'd1);
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_IN_PULSE:
                begin
                    if (amp >= cfg.end_thr)
                    begin
                        end_next = stamp;
                        sum_next = sat_add32(sum_reg, amp32);
                        cnt_next = sat_add16(cnt_reg, 16'd1);
                    end
                    else if (3'd1 >= pdw_pkg::END_RUN)
                    begin
                        push       = 1'b1;
                        seq_next   = seq_reg + 32'd1;
                        phase_next = PH_IDLE;
                        run_next   = 3'd0;
                    end
                    else
                    begin
                        run_next   = 3'd1;
                        phase_next = PH_MAYBE_END;
                        tsum_next  = amp32;
                        tcnt_next  = 16'd1;
                    end
                end
                PH_MAYBE_END:
                begin
                    if (amp < cfg.end_thr)
                    begin
                        if (run_inc >= pdw_pkg::END_RUN)
                        begin
                            // confirming sample is not summed; tail dropped
                            push       = 1'b1;
                            seq_next   = seq_reg + 32'd1;
                            phase_next = PH_IDLE;
                            run_next   = 3'd0;
                        end
                        else
                        begin
                            run_next  = run_inc;
                            tsum_next = sat_add32(tsum_reg, amp32);
                            tcnt_next = sat_add16(tcnt_reg, 16'd1);
                        end
                    end
                    else
                    begin
                        // pulse resumed: fold the tail back in
                        phase_next = PH_IN_PULSE;
                        end_next   = stamp;
                        sum_next   = sat_add32(sat_add32(sum_reg, tsum_reg), amp32);
                        cnt_next   = sat_add16(sat_add16(cnt_reg, tcnt_reg), 16'd1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            run_reg   <= 3'd0;
            start_reg <= 32'd0;
            end_reg   <= 32'd0;
            sum_reg   <= 32'd0;
            cnt_reg   <= 16'd0;
            tsum_reg  <= 32'd0;
            tcnt_reg  <= 16'd0;
            seq_reg   <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            tsum_reg  <= tsum_next;
            tcnt_reg  <= tcnt_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

[hdl/pdw_fifo.sv]
// ----------------------------------------------------------------------------
// pdw_fifo
// Short queue of pulse summaries between detector and divider.
// ----------------------------------------------------------------------------
module pdw_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pdw_pkg::summary_t      push_data,
    input  logic                   pop,
    output pdw_pkg::summary_t      pop_data,
    output pdw_pkg::fifo_status_t  status
);

    pdw_pkg::summary_t            mem_reg [pdw_pkg::FIFO_DEPTH];
    logic [pdw_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pdw_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pdw_pkg::FIFO_CW-1:0]  count_reg, count_next;

    localparam logic [pdw_pkg::FIFO_CW-1:0] DEPTH_C = pdw_pkg::FIFO_CW'(pdw_pkg::FIFO_DEPTH);
    localparam logic [pdw_pkg::FIFO_AW-1:0] LAST_C  =
        pdw_pkg::FIFO_AW'(pdw_pkg::FIFO_DEPTH - 1);

    assign status.full  = (count_reg == DEPTH_C);
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/pdw_back.sv]
// ----------------------------------------------------------------------------
// pdw_back
// Mean amplitude divider (one quotient bit per cycle) and output register.
// ----------------------------------------------------------------------------
module pdw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pdw_pkg::fifo_status_t  q_status,
    input  pdw_pkg::summary_t      q_data,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [111:0]           m_tdata    // [31:0] pulse_seq, [63:32] arrival_time,
                                              // [79:64] mean_amplitude, [111:80] pulse_width
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_HOLD
    } bstate_t;

    bstate_t      state_reg, state_next;
    logic [31:0]  seq_reg, seq_next;
    logic [31:0]  toa_reg, toa_next;
    logic [31:0]  width_reg, width_next;
    logic [15:0]  div_reg, div_next;     // divisor
    logic [15:0]  rem_reg, rem_next;
    logic [15:0]  quo_reg, quo_next;     // dividend low half shifting into quotient
    logic [3:0]   step_reg, step_next;
    logic         ovalid_reg, ovalid_next;
    logic [111:0] odata_reg, odata_next;

    logic [16:0]  trial;
    logic         fits;
    logic         load_out;

    assign trial    = {rem_reg, quo_reg[15]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign pop      = (state_reg == B_IDLE) && !q_status.empty;
    assign load_out = (state_reg == B_HOLD) && (!ovalid_reg || m_tready);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        state_next  = state_reg;
        seq_next    = seq_reg;
        toa_next    = toa_reg;
        width_next  = width_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    seq_next   = q_data.seq;
                    toa_next   = q_data.toa;
                    width_next = q_data.width;
                    div_next   = q_data.amp_cnt;
                    rem_next   = q_data.amp_sum[31:16];
                    quo_next   = q_data.amp_sum[15:0];
                    step_next  = 4'd15;
                    if (q_data.amp_cnt == 16'd0)
                    begin
                        quo_next   = 16'd0;
                        state_next = B_HOLD;
                    end
                    else if (q_data.amp_sum[31:16] >= q_data.amp_cnt)
                    begin
                        // quotient needs more than 16 bits: clamp
                        quo_next   = 16'hFFFF;
                        state_next = B_HOLD;
                    end
                    else
                    begin
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                rem_next  = fits ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
                quo_next  = {quo_reg[14:0], fits};
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0)
                    state_next = B_HOLD;
            end
            B_HOLD:
            begin
                if (load_out)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {width_reg, quo_reg, toa_reg, seq_reg};
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            seq_reg    <= '0;
            toa_reg    <= '0;
            width_reg  <= '0;
            div_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            seq_reg    <= seq_next;
            toa_reg    <= toa_next;
            width_reg  <= width_next;
            div_reg    <= div_next;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
        end
    end

endmodule

[hdl/pulse_detector_pdw_core.sv]
// ----------------------------------------------------------------------------
// pulse_detector_pdw_core
// Radar pulse detector emitting one pulse descriptor word per detected pulse.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one request per sample, tdata = amplitude and time.
//   Samples are taken one per cycle while the descriptor queue has room.
//   Master stream (m_*): one request per confirmed pulse end, carrying the
//   sequence number, arrival time, mean amplitude and pulse width.
//   APB port: start threshold (0x0), end threshold (0x4), sample period (0x8);
//   write only while no pulse is in flight.
// Timing:
//   One sample per cycle while the queue has room. After the edge that takes
//   the sample confirming a pulse end: queue write on that edge, one fetch,
//   16 bit-serial divider steps, one output register load (the divider steps
//   are skipped when a zero count or a clamped mean is seen). The divider takes
//   the next descriptor only once the last is loaded; a four-deep queue absorbs bursts.
// Reset: rst_n clears the detector to idle, empties the queue and restores
//   the register defaults (655, 655, 100). No memory clearing is needed.
// Stall: while m_tready is low the descriptor is held; the divider finishes
//   the next one and waits, and s_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_detector_pdw_core (
    input  logic         clk,
    input  logic         rst_n,
    // sample stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // [15:0] sample_amplitude, [47:16] sample_time
    // descriptor stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [31:0] pulse_seq, [63:32] arrival_time,
                                    // [79:64] mean_amplitude, [111:80] pulse_width
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0] start_thr_reg;
    logic [15:0] end_thr_reg;
    logic [15:0] period_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    pdw_pkg::cfg_t         cfg;
    pdw_pkg::summary_t     push_data;
    pdw_pkg::summary_t     pop_data;
    pdw_pkg::fifo_status_t q_status;
    logic                  push;
    logic                  pop;

    // ------------------------------------------------------------------
    // Configuration registers (word addressed, upper 16 data bits unused)
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_thr_reg <= pdw_pkg::START_THR_RST;
            end_thr_reg   <= pdw_pkg::END_THR_RST;
            period_reg    <= pdw_pkg::PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                pdw_pkg::REG_START_THR: start_thr_reg <= pwdata[15:0];
                pdw_pkg::REG_END_THR:   end_thr_reg   <= pwdata[15:0];
                pdw_pkg::REG_PERIOD:    period_reg    <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pdw_pkg::REG_START_THR: prdata = {16'd0, start_thr_reg};
            pdw_pkg::REG_END_THR:   prdata = {16'd0, end_thr_reg};
            pdw_pkg::REG_PERIOD:    prdata = {16'd0, period_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.start_thr = start_thr_reg;
    assign cfg.end_thr   = end_thr_reg;
    assign cfg.period    = period_reg;

    // ------------------------------------------------------------------
    // Detector -> queue -> divider
    // ------------------------------------------------------------------
    pdw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_status.full),
        .push      (push),
        .push_data (push_data)
    );

    pdw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    pdw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PDW_ASSERT_SAME(a_no_overflow, push, !q_status.full, "descriptor queue overflow")
    `PDW_ASSERT_SAME(a_no_underflow, pop, !q_status.empty, "descriptor queue underflow")
    `PDW_ASSERT_NEXT(a_pop_starts_work, pop, !pop, "divider fetched twice in a row")

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pulse_detector_pdw_core: samples go in on the s_*
// stream, a scoreboard tracks the detector phase, sums and counts per sample
// and queues the descriptor each confirmed pulse end should produce; every
// m_* descriptor is compared field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES = 40;   // wait for the pipeline to drain
    localparam int LONG_HOLD    = 400;  // receiver hold-off that backs up the queue

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MAYBE_START,
        PH_IN_PULSE,
        PH_MAYBE_END
    } detect_phase_t;

    // one pulse descriptor as it leaves the block
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] toa;
        logic [15:0] mean;
        logic [31:0] width;
    } pdw_t;

    // ------------------------------------------------------------------------
    // Scoreboard: per-sample detector tracking and descriptor checking
    // ------------------------------------------------------------------------
    class pdw_scoreboard;
        logic [15:0]   start_thr;
        logic [15:0]   end_thr;
        logic [15:0]   period;
        detect_phase_t phase;
        logic [2:0]    run_len;
        logic [31:0]   start_ts;
        logic [31:0]   end_ts;
        logic [31:0]   amp_sum;
        logic [15:0]   amp_cnt;
        logic [31:0]   tail_sum;
        logic [15:0]   tail_cnt;
        logic [31:0]   seq;
        pdw_t          pending_pdw[$];
        int            mismatches;

        function new();
            start_thr  = pdw_pkg::START_THR_RST;
            end_thr    = pdw_pkg::END_THR_RST;
            period     = pdw_pkg::PERIOD_RST;
            phase      = PH_IDLE;
            run_len    = '0;
            start_ts   = '0;
            end_ts     = '0;
            amp_sum    = '0;
            amp_cnt    = '0;
            tail_sum   = '0;
            tail_cnt   = '0;
            seq        = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                pdw_pkg::REG_START_THR: start_thr = val;
                pdw_pkg::REG_END_THR:   end_thr   = val;
                pdw_pkg::REG_PERIOD:    period    = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_pdw.size();
        endfunction

        function void flag(string what, logic [31:0] exp_val, logic [31:0] act_val);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch %s: expected %h, got %h", $realtime, what,
                         exp_val, act_val);
        endfunction

        function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [15:0] sat_cnt(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[16] ? 16'hFFFF : s[15:0];
        endfunction

        function logic [2:0] bump_run(logic [2:0] r);
            return (r >= 3'd7) ? 3'd7 : r + 3'd1;
        endfunction

        // end confirmed: build the descriptor and go back to idle
        function void close_pulse();
            logic [31:0] quot;
            pdw_t        w;
            seq     = seq + 32'd1;
            quot    = (amp_cnt != 0) ? amp_sum / {16'h0, amp_cnt} : 32'h0;
            w.seq   = seq;
            w.toa   = start_ts;
            w.mean  = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
            w.width = end_ts - start_ts + {16'h0, period};
            pending_pdw.push_back(w);
            phase   = PH_IDLE;
            run_len = '0;
        endfunction

        function void note_sample(logic [15:0] amp, logic [31:0] ts);
            case (phase)
                PH_IDLE:
                    if (amp >= start_thr)
                    begin
                        run_len  = 3'd1;
                        start_ts = ts;
                        end_ts   = ts;
                        amp_sum  = {16'h0, amp};
                        amp_cnt  = 16'd1;
                        phase    = (run_len >= pdw_pkg::START_RUN) ? PH_IN_PULSE
                                                                   : PH_MAYBE_START;
                    end
                PH_MAYBE_START:
                    if (amp >= start_thr)
                    begin
                        run_len = bump_run(run_len);
                        if (run_len >= pdw_pkg::START_RUN)
                            phase = PH_IN_PULSE;
                        end_ts  = ts;   // keeps short pulses off a stale end time
                        amp_sum = sat_sum(amp_sum, {16'h0, amp});
                        amp_cnt = sat_cnt(amp_cnt, 16'd1);
                    end
                    else
                        phase = PH_IDLE;
                PH_IN_PULSE:
                    if (amp >= end_thr)
                    begin
                        end_ts  = ts;
                        amp_sum = sat_sum(amp_sum, {16'h0, amp});
                        amp_cnt = sat_cnt(amp_cnt, 16'd1);
                    end
                    else
                    begin
                        run_len = 3'd1;
                        if (run_len >= pdw_pkg::END_RUN)
                            close_pulse();
                        else
                        begin
                            phase    = PH_MAYBE_END;
                            tail_sum = {16'h0, amp};
                            tail_cnt = 16'd1;
                        end
                    end
                default:
                    if (amp < end_thr)
                    begin
                        run_len = bump_run(run_len);
                        if (run_len >= pdw_pkg::END_RUN)
                            close_pulse();  // confirming sample is not summed
                        else
                        begin
                            tail_sum = sat_sum(tail_sum, {16'h0, amp});
                            tail_cnt = sat_cnt(tail_cnt, 16'd1);
                        end
                    end
                    else
                    begin
                        // pulse resumed: fold the tail back in
                        phase   = PH_IN_PULSE;
                        end_ts  = ts;
                        amp_sum = sat_sum(sat_sum(amp_sum, tail_sum), {16'h0, amp});
                        amp_cnt = sat_cnt(sat_cnt(amp_cnt, tail_cnt), 16'd1);
                    end
            endcase
        endfunction

        function void check_descriptor(logic [111:0] d);
            pdw_t w;
            if (pending_pdw.size() == 0)
            begin
                flag("descriptor with none pending", 32'h0, d[31:0]);
                return;
            end
            w = pending_pdw.pop_front();
            if (d[31:0] != w.seq)
                flag("pulse_seq", w.seq, d[31:0]);
            if (d[63:32] != w.toa)
                flag("arrival_time", w.toa, d[63:32]);
            if (d[79:64] != w.mean)
                flag("mean_amplitude", {16'h0, w.mean}, {16'h0, d[79:64]});
            if (d[111:80] != w.width)
                flag("pulse_width", w.width, d[111:80]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata  = '0;    // [15:0] sample_amplitude, [47:16] sample_time
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;          // [31:0] pulse_seq, [63:32] arrival_time,
                                    // [79:64] mean_amplitude, [111:80] pulse_width
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    pdw_scoreboard sb = new();

    logic [31:0] t_now;     // running sample timestamp
    bit          quiet;     // no idling on either side
    bit          hold_req;  // ask the receiver for its one long hold-off
    bit          hold_done;
    int          hold_cnt;
    int          stall_cnt;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pulse_detector_pdw_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cnt  <= LONG_HOLD - 1;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end
        else if (!quiet && $urandom_range(5, 0) == 0)
        begin
            stall_cnt <= $urandom_range(7, 1) - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // every accepted descriptor goes straight to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_descriptor(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // timestamps step by the sample period, with an occasional jump
    function automatic logic [31:0] next_ts();
        if ($urandom_range(15, 0) == 0)
            t_now = $urandom;
        else
            t_now = t_now + {16'h0, sb.period};
        return t_now;
    endfunction

    // at or above both thresholds: starts a pulse and keeps it going
    function automatic logic [15:0] amp_hi();
        logic [15:0] floor_v;
        floor_v = (sb.start_thr > sb.end_thr) ? sb.start_thr : sb.end_thr;
        return 16'($urandom_range(65535, floor_v));
    endfunction

    // below the end threshold (anything when nothing is below it)
    function automatic logic [15:0] amp_low();
        if (sb.end_thr == 0)
            return 16'($urandom);
        return 16'($urandom_range(sb.end_thr - 1, 0));
    endfunction

    // below the start threshold, keeps the detector idle
    function automatic logic [15:0] amp_quiet();
        if (sb.start_thr == 0)
            return 16'($urandom);
        return 16'($urandom_range(sb.start_thr - 1, 0));
    endfunction

    // one sample request; leaves tvalid high, returns at the falling edge
    task automatic send_sample(input logic [15:0] amp, input logic [31:0] ts);
        if (!quiet && $urandom_range(3, 0) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, amp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(amp, ts);
        @(negedge clk);
    endtask

    // APB write, then read back the same register
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != {16'h0, val})
            sb.flag("register readback", {16'h0, val}, rd);
    endtask

    task automatic set_config(input logic [15:0] s_thr, input logic [15:0] e_thr,
                              input logic [15:0] per);
        write_reg(pdw_pkg::REG_START_THR, s_thr);
        write_reg(pdw_pkg::REG_END_THR, e_thr);
        write_reg(pdw_pkg::REG_PERIOD, per);
    endtask

    // End any open pulse where the thresholds allow it, then wait for all
    // descriptors plus the pipeline latency so the block is idle.
    task automatic settle();
        if (sb.start_thr != 0 && sb.end_thr != 0)
            repeat (pdw_pkg::END_RUN) send_sample(16'h0000, next_ts());
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed pulses with random content: a quiet lead-in, a body
    // with occasional short dips, and an end run. Some false starts and
    // plain noise mixed in.
    task automatic random_bursts(input int n_items);
        int sent;
        int body;
        int k;
        int j;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                send_sample(16'($urandom), next_ts());
                sent++;
            end
            else
            begin
                repeat ($urandom_range(2, 0))
                begin
                    send_sample(amp_quiet(), next_ts());
                    sent++;
                end
                if ($urandom_range(7, 0) == 0)
                    body = $urandom_range(pdw_pkg::START_RUN - 1, 1);   // false start
                else
                    body = $urandom_range(pdw_pkg::START_RUN + 10, pdw_pkg::START_RUN);
                for (k = 0; k < body; k++)
                begin
                    if (k >= pdw_pkg::START_RUN && $urandom_range(6, 0) == 0)
                    begin
                        for (j = $urandom_range(pdw_pkg::END_RUN - 1, 1); j > 0; j--)
                        begin
                            send_sample(amp_low(), next_ts());
                            sent++;
                        end
                    end
                    send_sample(amp_hi(), next_ts());
                    sent++;
                end
                repeat (pdw_pkg::END_RUN + $urandom_range(2, 0))
                begin
                    send_sample(amp_low(), next_ts());
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] s_thr, input logic [15:0] e_thr,
                             input logic [15:0] per, input int n_items);
        set_config(s_thr, e_thr, per);
        random_bursts(n_items);
        settle();
    endtask

    // Receiver holds off while short pulses keep coming: the descriptor
    // queue fills and the sample side must stall.
    task automatic burst_under_hold();
        int k;
        hold_req = 1'b1;
        for (k = 0; k < 12; k++)
        begin
            repeat (pdw_pkg::START_RUN) send_sample(amp_hi(), next_ts());
            repeat (pdw_pkg::END_RUN) send_sample(amp_low(), next_ts());
        end
    endtask

    // One long pulse at full scale with a short dip that is merged back.
    task automatic fullscale_pulse();
        int k;
        for (k = 0; k < 40; k++)
            send_sample(16'hFFFF, next_ts());
        send_sample(16'h0000, next_ts());
        send_sample(16'h0001, next_ts());
        send_sample(16'hFFFF, next_ts());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] s_thr;
        logic [15:0] e_thr;
        int          k;

        quiet    = 1'b0;
        hold_req = 1'b0;
        t_now    = 32'hFFFF_FF00;   // directed part crosses the time wrap
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, reset thresholds 655/655 and period 100.
        // Below start, then a start run hitting the threshold exactly.
        send_sample(16'h0000, next_ts());
        send_sample(16'd654, next_ts());
        send_sample(16'd655, next_ts());
        send_sample(16'hFFFF, next_ts());
        send_sample(16'h8000, next_ts());
        // two-sample tail, then the pulse resumes and the tail is merged
        send_sample(16'd654, next_ts());
        send_sample(16'h0000, next_ts());
        send_sample(16'd700, next_ts());
        send_sample(16'hFFFF, next_ts());
        // end run; the confirming sample is not summed
        send_sample(16'h0000, next_ts());
        send_sample(16'h0001, next_ts());
        send_sample(16'd654, next_ts());
        // false start falls back to idle
        send_sample(16'd1000, next_ts());
        send_sample(16'd2000, next_ts());
        send_sample(16'd5, next_ts());
        // pulse made only of start samples: width uses the last start sample
        send_sample(16'h5555, next_ts());
        send_sample(16'hAAAA, next_ts());
        send_sample(16'd655, next_ts());
        send_sample(16'h0000, next_ts());
        send_sample(16'h0000, next_ts());
        send_sample(16'h0000, next_ts());
        settle();

        // register extremes
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
        run_phase(16'h0000, 16'h0000, 16'h0000, 30);  // every sample in pulse, no ends
        run_phase(16'h0001, 16'h0001, 16'hFFFF, 40);

        // queue fill under a long receiver hold-off
        set_config(16'd2000, 16'd1500, 16'd250);
        random_bursts(20);
        burst_under_hold();
        settle();

        // random settings, end threshold mostly at or below start
        for (k = 0; k < 4; k++)
        begin
            s_thr = 16'($urandom_range(65535, 1));
            if ($urandom_range(3, 0) == 0)
                e_thr = 16'($urandom_range(65535, 1));
            else
                e_thr = 16'($urandom_range(s_thr, 1));
            run_phase(s_thr, e_thr, 16'($urandom), 35);
        end

        set_config(pdw_pkg::START_THR_RST, pdw_pkg::END_THR_RST, pdw_pkg::PERIOD_RST);
        fullscale_pulse();
        settle();

        // last stretch with no idling on either side
        quiet = 1'b1;
        s_thr = 16'($urandom_range(40000, 100));
        e_thr = 16'($urandom_range(s_thr, 1));
        run_phase(s_thr, e_thr, 16'($urandom), 60);

        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
